/* hdl/cscan_pkg.sv */
// Shared types and constants for the C-SCAN disk scheduler.
`timescale 1ns / 1ps
package cscan_pkg;

  localparam int unsigned TRACK_W = 12;
  localparam int unsigned MOVE_W  = 14;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // stop kinds
  localparam logic [KIND_W-1:0] KIND_SERVED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRAP   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_TRACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TRACK   = 2'd1;

  // configuration reset values
  localparam logic [TRACK_W-1:0] START_TRACK_RST = 12'd50;
  localparam logic [TRACK_W-1:0] MAX_TRACK_RST   = 12'd199;

  typedef logic [TRACK_W-1:0] track_t;
  typedef logic [MOVE_W-1:0]  move_t;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0] stop_kind;
    track_t            stop_track;
    move_t             total_movement;
    logic              last;
  } stop_t;

endpackage

/* hdl/cscan_if.sv */
// Handshake channel interfaces: request, stop result and configuration write.
`timescale 1ns / 1ps
interface cscan_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [cscan_pkg::TRACK_W-1:0] track;

  modport source (output valid, output cmd, output track, input ready);
  modport sink   (input valid, input cmd, input track, output ready);
endinterface

interface cscan_stop_if;
  logic                          valid;
  logic                          ready;
  logic [cscan_pkg::KIND_W-1:0]  stop_kind;
  logic [cscan_pkg::TRACK_W-1:0] stop_track;
  logic [cscan_pkg::MOVE_W-1:0]  total_movement;
  logic                          last;

  modport source (output valid, output stop_kind, output stop_track,
                  output total_movement, output last, input ready);
  modport sink   (input valid, input stop_kind, input stop_track,
                  input total_movement, input last, output ready);
endinterface

interface cscan_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cscan_pkg::CFG_IDX_W-1:0] index;
  logic [cscan_pkg::TRACK_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/cscan_store.sv */
// Request store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module cscan_store #(
  parameter int unsigned MAX_PENDING = 16,
  localparam int unsigned IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [IDX_W-1:0]              waddr_i,
  input  logic [cscan_pkg::TRACK_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]              raddr_i,
  output logic [cscan_pkg::TRACK_W-1:0] rdata_o
);
  import cscan_pkg::*;

  track_t mem [MAX_PENDING];
  track_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/cscan_ctrl.sv */
// Sequencer: loads requests, scans the store for the next stop, emits stops.
`timescale 1ns / 1ps
module cscan_ctrl #(
  parameter int unsigned MAX_PENDING = 16,
  localparam int unsigned IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_PENDING + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic                          req_cmd_i,
  input  logic [cscan_pkg::TRACK_W-1:0] req_track_i,
  // configuration
  input  logic [cscan_pkg::TRACK_W-1:0] start_track_i,
  input  logic [cscan_pkg::TRACK_W-1:0] max_track_i,
  // store ports
  output logic                          mem_we_o,
  output logic [IDX_W-1:0]              mem_waddr_o,
  output logic [cscan_pkg::TRACK_W-1:0] mem_wdata_o,
  output logic [IDX_W-1:0]              mem_raddr_o,
  input  logic [cscan_pkg::TRACK_W-1:0] mem_rdata_i,
  // stop channel
  output logic                          stop_valid_o,
  input  logic                          stop_ready_i,
  output cscan_pkg::stop_t              stop_o
);
  import cscan_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_END,
    ST_WRAP
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       remain_q, remain_d;
  logic [MAX_PENDING-1:0] served_q, served_d;
  logic                   wrapped_q, wrapped_d;
  track_t                 base_q, base_d;   // sweep start, clamped
  track_t                 head_q, head_d;
  move_t                  move_q, move_d;
  // scan bookkeeping
  logic [CNT_W-1:0]       issue_q, issue_d;
  logic                   rd_valid_q, rd_valid_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   best_found_q, best_found_d;
  logic                   best_low_q, best_low_d;
  track_t                 best_trk_q, best_trk_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  // output register
  logic                   out_valid_q, out_valid_d;
  stop_t                  out_q, out_d;

  logic   req_acc;
  logic   out_free;
  logic   cand_low;
  track_t load_trk;

  assign req_ready_o  = (state_q == ST_IDLE);
  assign req_acc      = req_valid_i && req_ready_o;
  assign out_free     = !out_valid_q || stop_ready_i;
  assign cand_low     = (mem_rdata_i < base_q);
  assign load_trk     = (req_track_i > max_track_i) ? max_track_i : req_track_i;

  assign mem_we_o     = req_acc && (req_cmd_i == CMD_LOAD) &&
                        (count_q < CNT_W'(MAX_PENDING));
  assign mem_waddr_o  = count_q[IDX_W-1:0];
  assign mem_wdata_o  = load_trk;
  assign mem_raddr_o  = issue_q[IDX_W-1:0];

  assign stop_valid_o = out_valid_q;
  assign stop_o       = out_q;

  // next-state logic
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    remain_d     = remain_q;
    served_d     = served_q;
    wrapped_d    = wrapped_q;
    base_d       = base_q;
    head_d       = head_q;
    move_d       = move_q;
    issue_d      = issue_q;
    rd_valid_d   = 1'b0;
    rd_idx_d     = rd_idx_q;
    best_found_d = best_found_q;
    best_low_d   = best_low_q;
    best_trk_d   = best_trk_q;
    best_idx_d   = best_idx_q;
    out_valid_d  = out_valid_q && !stop_ready_i;
    out_d        = out_q;

    case (state_q)
      ST_IDLE: begin
        if (mem_we_o) begin
          count_d = count_q + CNT_W'(1);
        end
        if (req_acc && (req_cmd_i == CMD_RUN)) begin
          base_d       = (start_track_i > max_track_i) ? max_track_i : start_track_i;
          head_d       = base_d;
          move_d       = '0;
          remain_d     = count_q;
          served_d     = '0;
          wrapped_d    = 1'b0;
          issue_d      = '0;
          best_found_d = 1'b0;
          state_d      = (count_q == '0) ? ST_END : ST_SCAN;
        end
      end

      // sweep all entries, keep the smallest unserved key
      ST_SCAN: begin
        if (issue_q < count_q) begin
          issue_d    = issue_q + CNT_W'(1);
          rd_valid_d = 1'b1;
          rd_idx_d   = issue_q[IDX_W-1:0];
        end
        if (rd_valid_q) begin
          if (!served_q[rd_idx_q] &&
              (!best_found_q ||
               ({cand_low, mem_rdata_i} < {best_low_q, best_trk_q}))) begin
            best_found_d = 1'b1;
            best_low_d   = cand_low;
            best_trk_d   = mem_rdata_i;
            best_idx_d   = rd_idx_q;
          end
          if (CNT_W'(rd_idx_q) == count_q - CNT_W'(1)) begin
            state_d = ST_PICK;
          end
        end
      end

      ST_PICK: begin
        if (best_low_q && !wrapped_q) begin
          state_d = ST_END;
        end else if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.stop_kind      = KIND_SERVED;
          out_d.stop_track     = best_trk_q;
          out_d.total_movement = move_q + MOVE_W'(best_trk_q - head_q);
          out_d.last           = wrapped_q && (remain_q == CNT_W'(1));
          move_d               = out_d.total_movement;
          head_d               = best_trk_q;
          served_d[best_idx_q] = 1'b1;
          remain_d             = remain_q - CNT_W'(1);
          issue_d              = '0;
          best_found_d         = 1'b0;
          if (remain_q == CNT_W'(1)) begin
            if (wrapped_q) begin
              count_d = '0;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_END;
            end
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      // head reaches the disk end; the head may sit above a lowered disk end,
      // so the step is taken modulo the movement width
      ST_END: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.stop_kind      = KIND_END;
          out_d.stop_track     = max_track_i;
          out_d.total_movement = move_q + MOVE_W'(max_track_i) - MOVE_W'(head_q);
          out_d.last           = 1'b0;
          move_d               = out_d.total_movement;
          head_d               = max_track_i;
          state_d              = ST_WRAP;
        end
      end

      // jump to track zero, no movement added
      ST_WRAP: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.stop_kind      = KIND_WRAP;
          out_d.stop_track     = '0;
          out_d.total_movement = move_q;
          out_d.last           = (remain_q == '0);
          head_d               = '0;
          wrapped_d            = 1'b1;
          if (remain_q == '0) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_PICK;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      remain_q     <= '0;
      served_q     <= '0;
      wrapped_q    <= 1'b0;
      issue_q      <= '0;
      rd_valid_q   <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      remain_q     <= remain_d;
      served_q     <= served_d;
      wrapped_q    <= wrapped_d;
      issue_q      <= issue_d;
      rd_valid_q   <= rd_valid_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    head_q     <= head_d;
    move_q     <= move_d;
    rd_idx_q   <= rd_idx_d;
    best_low_q <= best_low_d;
    best_trk_q <= best_trk_d;
    best_idx_q <= best_idx_d;
    out_q      <= out_d;
  end

endmodule

/* hdl/cscan_disk_scheduler.sv */
// Top level of the C-SCAN disk scheduler.
//
//   channel   dir   fields                                        notes
//   req_i     in    cmd, track                                    load or run
//   cfg_i     in    index, data                                   0 start, 1 max
//   stop_o    out   stop_kind, stop_track, total_movement, last   one per stop
//
// A load is taken while the block is idle. A run holds the block until its
// last stop: each served stop rescans the store through its single read
// port and then passes the pick state; disk end and wrap take a state each.
// Reset clears the request count and sets the configuration to its reset values; no clearing pass.
// A stalled stop channel holds the sequencer until the output register frees.
`timescale 1ns / 1ps
module cscan_disk_scheduler #(
  parameter int unsigned MAX_PENDING = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cscan_req_if.sink    req_i,
  cscan_cfg_if.sink    cfg_i,
  cscan_stop_if.source stop_o
);
  import cscan_pkg::*;

  localparam int unsigned IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

  track_t           start_q, max_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  track_t           mem_wdata, mem_rdata;
  stop_t            stop;
  logic             req_ready;
  logic             stop_valid;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_TRACK_RST;
      max_q   <= MAX_TRACK_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_START_TRACK: start_q <= cfg_i.data;
        REG_MAX_TRACK:   max_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  cscan_store #(
    .MAX_PENDING (MAX_PENDING)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cscan_ctrl #(
    .MAX_PENDING (MAX_PENDING)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_ready),
    .req_cmd_i     (req_i.cmd),
    .req_track_i   (req_i.track),
    .start_track_i (start_q),
    .max_track_i   (max_q),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .stop_valid_o  (stop_valid),
    .stop_ready_i  (stop_o.ready),
    .stop_o        (stop)
  );

  assign req_i.ready           = req_ready;
  assign stop_o.valid          = stop_valid;
  assign stop_o.stop_kind      = stop.stop_kind;
  assign stop_o.stop_track     = stop.stop_track;
  assign stop_o.total_movement = stop.total_movement;
  assign stop_o.last           = stop.last;

endmodule

/* hdl/cscan_checker.sv */
// Port-level checks for the C-SCAN disk scheduler, bound to the top level.
`timescale 1ns / 1ps
module cscan_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_ready_i,
  input logic                          stop_valid_i,
  input logic                          stop_ready_i,
  input logic [cscan_pkg::KIND_W-1:0]  stop_kind_i,
  input logic [cscan_pkg::TRACK_W-1:0] stop_track_i,
  input logic [cscan_pkg::MOVE_W-1:0]  total_movement_i,
  input logic                          last_i
);
  import cscan_pkg::*;

  // a stalled stop keeps its payload
  a_stop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_valid_i && !stop_ready_i |=>
      stop_valid_i && $stable(stop_kind_i) && $stable(stop_track_i) &&
      $stable(total_movement_i) && $stable(last_i))
    else $error("stop item changed while stalled");

  // the wrap stop always lands on track zero
  a_wrap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_valid_i && (stop_kind_i == KIND_WRAP) |-> (stop_track_i == '0))
    else $error("wrap stop not at track zero");

  // the disk end stop never closes a run
  a_end_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_valid_i && (stop_kind_i == KIND_END) |-> !last_i)
    else $error("disk end stop flagged last");

  // a run blocks new requests until its last stop has been produced
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_valid_i && stop_ready_i && !last_i |-> !req_ready_i)
    else $error("request taken in the middle of a run");

endmodule

bind cscan_disk_scheduler cscan_checker u_cscan_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_ready_i      (req_i.ready),
  .stop_valid_i     (stop_o.valid),
  .stop_ready_i     (stop_o.ready),
  .stop_kind_i      (stop_o.stop_kind),
  .stop_track_i     (stop_o.stop_track),
  .total_movement_i (stop_o.total_movement),
  .last_i           (stop_o.last)
);
